// ----- hw/rtl/point_in_polygon_winding_macros.svh -----
// Assertion macros for the point-in-polygon winding classifier.
`ifndef POINT_IN_POLYGON_WINDING_MACROS_SVH
`define POINT_IN_POLYGON_WINDING_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PIPW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PIPW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/pipw_pkg.sv -----
// Shared types, constants and helpers for the point-in-polygon winding classifier.
`timescale 1ns / 1ps
`default_nettype none

package pipw_pkg;

  localparam int FIELD_W = 16;
  localparam int CRD_W   = 17;
  localparam int DIF_W   = CRD_W + 1;
  localparam int MUL_W   = 2 * DIF_W;
  localparam int PRD_W   = MUL_W + 1;
  localparam int WIND_W  = 16;
  localparam int LOC_W   = 2;

  typedef logic signed [FIELD_W-1:0] field_t;
  typedef logic signed [CRD_W-1:0]   crd_t;
  typedef logic signed [DIF_W-1:0]   dif_t;
  typedef logic signed [MUL_W-1:0]   mul_t;
  typedef logic signed [PRD_W-1:0]   prd_t;
  typedef logic signed [WIND_W-1:0]  wind_t;
  typedef logic [LOC_W-1:0]          loc_t;

  localparam loc_t LOC_OUTSIDE  = 2'd0;
  localparam loc_t LOC_INSIDE   = 2'd1;
  localparam loc_t LOC_BOUNDARY = 2'd2;

  localparam wind_t WIND_MAX = 16'sh7FFF;
  localparam wind_t WIND_MIN = 16'sh8000;

  typedef struct packed {
    logic on_bnd;
    logic up;
    logic down;
  } seg_res_t;

  // saturating winding update for one segment
  function automatic wind_t wind_step(wind_t w, seg_res_t r);
    wind_t res;
    res = w;
    if (r.up && (w != WIND_MAX)) begin
      res = w + 16'sd1;
    end else if (r.down && (w != WIND_MIN)) begin
      res = w - 16'sd1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pipw_ifs.sv -----
// Valid/ready channel interfaces for vertex input and classification output.
`timescale 1ns / 1ps
`default_nettype none

interface pipw_in_if;
  logic            valid;
  logic            ready;
  pipw_pkg::field_t point_x;
  pipw_pkg::field_t point_y;
  pipw_pkg::field_t vertex_x;
  pipw_pkg::field_t vertex_y;
  logic            first_vertex;
  logic            last_vertex;

  modport source (
    output valid, point_x, point_y, vertex_x, vertex_y, first_vertex, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, vertex_x, vertex_y, first_vertex, last_vertex,
    output ready
  );
endinterface

interface pipw_out_if;
  logic            valid;
  logic            ready;
  pipw_pkg::loc_t  location;
  pipw_pkg::wind_t winding;

  modport source (
    output valid, location, winding,
    input  ready
  );
  modport sink (
    input  valid, location, winding,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/pipw_seg.sv -----
// Exact segment test: on-boundary check and winding crossing direction.
`timescale 1ns / 1ps
`default_nettype none

module pipw_seg (
  input  pipw_pkg::crd_t     ax,
  input  pipw_pkg::crd_t     ay,
  input  pipw_pkg::crd_t     bx,
  input  pipw_pkg::crd_t     by,
  input  pipw_pkg::crd_t     qx,
  input  pipw_pkg::crd_t     qy,
  output pipw_pkg::seg_res_t res
);

  pipw_pkg::dif_t pax, pay, pbx, pby, ex, ey;
  pipw_pkg::mul_t m_ab, m_ba, m_xx, m_yy, m_ke, m_kp;
  pipw_pkg::prd_t crs, dt, kv;
  logic pay_le0, pay_gt0, pby_le0, pby_gt0;

  assign pax = pipw_pkg::dif_t'(ax) - pipw_pkg::dif_t'(qx);
  assign pay = pipw_pkg::dif_t'(ay) - pipw_pkg::dif_t'(qy);
  assign pbx = pipw_pkg::dif_t'(bx) - pipw_pkg::dif_t'(qx);
  assign pby = pipw_pkg::dif_t'(by) - pipw_pkg::dif_t'(qy);
  assign ex  = pipw_pkg::dif_t'(bx) - pipw_pkg::dif_t'(ax);
  assign ey  = pipw_pkg::dif_t'(by) - pipw_pkg::dif_t'(ay);

  assign m_ab = pax * pby;
  assign m_ba = pbx * pay;
  assign m_xx = pax * pbx;
  assign m_yy = pay * pby;
  assign m_kp = pax * ey;
  assign m_ke = ex * pay;

  assign crs = pipw_pkg::prd_t'(m_ab) - pipw_pkg::prd_t'(m_ba);
  assign dt  = pipw_pkg::prd_t'(m_xx) + pipw_pkg::prd_t'(m_yy);
  // orientation of the point against the directed segment
  assign kv  = pipw_pkg::prd_t'(m_kp) - pipw_pkg::prd_t'(m_ke);

  assign pay_le0 = pay[pipw_pkg::DIF_W-1] || (pay == pipw_pkg::dif_t'(0));
  assign pay_gt0 = !pay_le0;
  assign pby_le0 = pby[pipw_pkg::DIF_W-1] || (pby == pipw_pkg::dif_t'(0));
  assign pby_gt0 = !pby_le0;

  always_comb begin
    res.on_bnd = (crs == pipw_pkg::prd_t'(0)) &&
                 (dt[pipw_pkg::PRD_W-1] || (dt == pipw_pkg::prd_t'(0)));
    res.up     = !kv[pipw_pkg::PRD_W-1] && (kv != pipw_pkg::prd_t'(0)) &&
                 pay_le0 && pby_gt0;
    res.down   = kv[pipw_pkg::PRD_W-1] && pby_le0 && pay_gt0;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/point_in_polygon_winding.sv -----
// Top level: streamed-vertex winding-number point-in-polygon classifier.
// Usage:
//   in_ch carries one polygon vertex per transaction. first_vertex starts a
//   polygon and latches point_x/point_y as the query point; point fields are
//   ignored otherwise. last_vertex closes the polygon back to its first vertex.
//   out_ch gives one transaction per last_vertex item: location (0 outside,
//   1 inside, 2 on boundary) and the final winding number (0 on boundary).
// Timing:
//   An accepted item sits in the input register, then both segment tests and
//   the winding update run combinationally into the output register, which
//   offers the result on out_ch.
//   One item per cycle sustained unless a last_vertex item waits behind a
//   held result; the input and output registers each hold one transaction.
// Reset: rst_n low empties both registers and zeroes the query point, first
//   and previous vertex, winding count and boundary flag.
// Stall: while out_ch.ready is low the result holds; in_ch.ready drops only
//   when a last_vertex item waits behind a held result.
`timescale 1ns / 1ps
`default_nettype none
`include "point_in_polygon_winding_macros.svh"

module point_in_polygon_winding #(
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  pipw_in_if.sink     in_ch,
  pipw_out_if.source  out_ch
);

  localparam int EFF_BITS = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int SHIFT    = 16 - EFF_BITS;
  localparam bit SIGN_EXT = (COORD_BITS <= 16);

  function automatic pipw_pkg::crd_t coord_of(logic [15:0] raw);
    logic [15:0] sh;
    sh = raw << SHIFT;
    if (SIGN_EXT) begin
      return pipw_pkg::crd_t'($signed(sh) >>> SHIFT);
    end
    return pipw_pkg::crd_t'({1'b0, raw});
  endfunction

  // input register
  logic           s1_valid_r;
  pipw_pkg::crd_t s1_px_r, s1_py_r, s1_vx_r, s1_vy_r;
  logic           s1_first_r, s1_last_r;

  // polygon state
  pipw_pkg::crd_t  qx_r, qy_r, sx_r, sy_r, prx_r, pry_r;
  pipw_pkg::wind_t wind_r;
  logic            bnd_r;

  // output register
  logic            out_valid_r;
  pipw_pkg::loc_t  out_loc_r;
  pipw_pkg::wind_t out_wind_r;

  logic              s1_go, in_fire;
  pipw_pkg::crd_t    q_x, q_y, st_x, st_y;
  pipw_pkg::seg_res_t seg0_res, seg1_res;
  pipw_pkg::wind_t   w0, w1;
  logic              b0, b1;

  assign s1_go   = s1_valid_r && (!s1_last_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_fire = in_ch.valid && in_ch.ready;

  assign q_x  = s1_first_r ? s1_px_r : qx_r;
  assign q_y  = s1_first_r ? s1_py_r : qy_r;
  assign st_x = s1_first_r ? s1_vx_r : sx_r;
  assign st_y = s1_first_r ? s1_vy_r : sy_r;

  // previous vertex to current vertex
  pipw_seg u_seg_prev (
    .ax (prx_r), .ay (pry_r), .bx (s1_vx_r), .by (s1_vy_r),
    .qx (qx_r),  .qy (qy_r),  .res (seg0_res)
  );

  // closing segment back to the first vertex
  pipw_seg u_seg_close (
    .ax (s1_vx_r), .ay (s1_vy_r), .bx (st_x), .by (st_y),
    .qx (q_x),     .qy (q_y),     .res (seg1_res)
  );

  always_comb begin
    if (s1_first_r) begin
      w0 = '0;
      b0 = 1'b0;
    end else begin
      w0 = pipw_pkg::wind_step(wind_r, seg0_res);
      b0 = bnd_r | seg0_res.on_bnd;
    end
    w1 = pipw_pkg::wind_step(w0, seg1_res);
    b1 = b0 | seg1_res.on_bnd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (in_fire) begin
      s1_px_r    <= coord_of(in_ch.point_x);
      s1_py_r    <= coord_of(in_ch.point_y);
      s1_vx_r    <= coord_of(in_ch.vertex_x);
      s1_vy_r    <= coord_of(in_ch.vertex_y);
      s1_first_r <= in_ch.first_vertex;
      s1_last_r  <= in_ch.last_vertex;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qx_r   <= '0;
      qy_r   <= '0;
      sx_r   <= '0;
      sy_r   <= '0;
      prx_r  <= '0;
      pry_r  <= '0;
      wind_r <= '0;
      bnd_r  <= 1'b0;
    end else if (s1_go) begin
      qx_r  <= q_x;
      qy_r  <= q_y;
      sx_r  <= st_x;
      sy_r  <= st_y;
      prx_r <= s1_vx_r;
      pry_r <= s1_vy_r;
      if (s1_last_r) begin
        wind_r <= '0;
        bnd_r  <= 1'b0;
      end else begin
        wind_r <= w0;
        bnd_r  <= b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_go && s1_last_r) begin
      if (b1) begin
        out_loc_r  <= pipw_pkg::LOC_BOUNDARY;
        out_wind_r <= '0;
      end else begin
        out_loc_r  <= (w1 != '0) ? pipw_pkg::LOC_INSIDE : pipw_pkg::LOC_OUTSIDE;
        out_wind_r <= w1;
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.location = out_loc_r;
  assign out_ch.winding  = out_wind_r;

  `PIPW_ASSERT_IMPL(a_bnd_wind_zero, out_valid_r && (out_loc_r == pipw_pkg::LOC_BOUNDARY), out_wind_r == '0, "boundary result with nonzero winding")
  `PIPW_ASSERT_IMPL(a_loc_matches_wind, out_valid_r && (out_loc_r != pipw_pkg::LOC_BOUNDARY), (out_loc_r == pipw_pkg::LOC_INSIDE) == (out_wind_r != '0), "location disagrees with winding")
  `PIPW_ASSERT_NEXT(a_clear_after_last, s1_go && s1_last_r, (wind_r == '0) && !bnd_r, "polygon state not cleared after result")
  `PIPW_ASSERT_IMPL(a_stall_cause, !in_ch.ready, s1_valid_r && s1_last_r && out_valid_r && !out_ch.ready, "input stalled without a held result")

endmodule

`default_nettype wire
